// File: design/rmbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_pkg: shared types and constants of the run-length bitmap decoder
// Field widths, configuration register indexes, reset values and the
// decode result that travels from the run control to the output stage.
// ----------------------------------------------------------------------------
package rmbd_pkg;

    // Payload field widths.
    localparam int BYTE_W      = 8;
    localparam int PIX_BYTES_W = 64;
    localparam int PIX_CNT_W   = 4;
    localparam int REPEAT_W    = 7;
    localparam int PIX_PER_BYTE = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONO_MODE = 2'd0,
        CFG_FG_COLOR  = 2'd1,
        CFG_BG_COLOR  = 2'd2
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic              MONO_MODE_RST = 1'b0;
    localparam logic [BYTE_W-1:0] FG_COLOR_RST  = 8'h00;
    localparam logic [BYTE_W-1:0] BG_COLOR_RST  = 8'hFF;

    // Pixel counts reported with each result.
    localparam logic [PIX_CNT_W-1:0] PIX_CNT_BYTE = 4'd1;
    localparam logic [PIX_CNT_W-1:0] PIX_CNT_MONO = 4'd8;

    // Repeat count of a single literal byte.
    localparam logic [REPEAT_W-1:0] REPEAT_ONE = 7'd1;

    // Decision made by the run control for one stream byte.
    typedef struct packed {
        logic                emit;
        logic [REPEAT_W-1:0] repeat_count;
    } t_run_dec;

endpackage
`default_nettype wire

// File: design/rmbd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_in_if: compressed byte stream channel
// Valid/ready channel that carries one stream byte and its end-of-image flag.
// ----------------------------------------------------------------------------
interface rmbd_in_if;
    import rmbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_of_image;

    modport source (output valid, output in_byte, output last_of_image, input ready);
    modport sink   (input valid, input in_byte, input last_of_image, output ready);
endinterface
`default_nettype wire

// File: design/rmbd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_out_if: pixel group channel
// Valid/ready channel that carries one pixel group and its repeat count.
// ----------------------------------------------------------------------------
interface rmbd_out_if;
    import rmbd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PIX_BYTES_W-1:0] pixel_bytes;
    logic [PIX_CNT_W-1:0]   pixel_count;
    logic [REPEAT_W-1:0]    repeat_count;

    modport source (output valid, output pixel_bytes, output pixel_count,
                    output repeat_count, input ready);
    modport sink   (input valid, input pixel_bytes, input pixel_count,
                    input repeat_count, output ready);
endinterface
`default_nettype wire

// File: design/rmbd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_in_stage: input register
// Captures one stream byte per transaction and hands it on whenever the
// output stage can take the outcome.
// ----------------------------------------------------------------------------
module rmbd_in_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rmbd_in_if.sink                          in_ch,
    input  wire logic                        i_s2_free,
    output logic                             o_adv,
    output logic [rmbd_pkg::BYTE_W-1:0]      o_byte,
    output logic                             o_last
);
    import rmbd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              n_valid;
    logic              accept;

    // The held byte moves on when the output stage is free.
    assign o_adv       = r_valid && i_s2_free;
    assign in_ch.ready = !r_valid || i_s2_free;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_adv) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= in_ch.in_byte;
            r_last <= in_ch.last_of_image;
        end
    end

    assign o_byte = r_byte;
    assign o_last = r_last;

endmodule
`default_nettype wire

// File: design/rmbd_run_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_run_ctrl: signed run counter
// Decides whether a byte is a count, a repeated data byte or a literal, and
// steps the run counter accordingly.
// ----------------------------------------------------------------------------
module rmbd_run_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [rmbd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_last,
    output rmbd_pkg::t_run_dec               o_dec
);
    import rmbd_pkg::*;

    logic [BYTE_W-1:0] r_run;
    logic [BYTE_W-1:0] n_run;

    // Role of the byte follows from the counter value.
    always_comb begin
        o_dec = '0;
        n_run = r_run;
        if (r_run == '0) begin
            // Count byte: load it, nothing is emitted.
            n_run = i_byte;
        end else if (!r_run[BYTE_W-1]) begin
            // Positive run: one data byte repeated, counter back to zero.
            o_dec.emit         = 1'b1;
            o_dec.repeat_count = r_run[REPEAT_W-1:0];
            n_run              = '0;
        end else begin
            // Literal sequence: one byte out, counter steps toward zero.
            o_dec.emit         = 1'b1;
            o_dec.repeat_count = REPEAT_ONE;
            n_run              = r_run + BYTE_W'(1);
        end
        // The end of an image abandons any pending run.
        if (i_last) begin
            n_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_adv) begin
            r_run <= n_run;
        end
    end

    // An emitted group is always written at least once.
    a_emit_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.emit |-> o_dec.repeat_count != '0)
        else $error("emitted group with zero repeat count");

    // The counter is clear after the last byte of an image.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> r_run == '0)
        else $error("run counter not cleared after last byte");

    // A count byte is loaded into the counter as it stands.
    a_count_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_last && r_run == '0) |=> r_run == $past(i_byte))
        else $error("count byte not loaded into run counter");

endmodule
`default_nettype wire

// File: design/rmbd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmbd_out_stage: pixel formatting and result register
// Holds the configuration registers, turns a data byte into its pixel group
// and keeps the result until the sink takes it.
// ----------------------------------------------------------------------------
module rmbd_out_stage (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rmbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmbd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_adv,
    input  wire logic [rmbd_pkg::BYTE_W-1:0]     i_byte,
    input  wire rmbd_pkg::t_run_dec              i_dec,
    output logic                                 o_s2_free,
    rmbd_out_if.source                           out_ch
);
    import rmbd_pkg::*;

    logic                   r_mono_mode;
    logic [BYTE_W-1:0]      r_fg_color;
    logic [BYTE_W-1:0]      r_bg_color;
    logic                   r_valid;
    logic [PIX_BYTES_W-1:0] r_pixel_bytes;
    logic [PIX_CNT_W-1:0]   r_pixel_count;
    logic [REPEAT_W-1:0]    r_repeat_count;
    logic [PIX_BYTES_W-1:0] n_pixel_bytes;
    logic [PIX_CNT_W-1:0]   n_pixel_count;
    logic                   load;

    // Configuration register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode <= MONO_MODE_RST;
            r_fg_color  <= FG_COLOR_RST;
            r_bg_color  <= BG_COLOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MONO_MODE: r_mono_mode <= i_cfg_wdata[0];
                CFG_FG_COLOR:  r_fg_color  <= i_cfg_wdata[BYTE_W-1:0];
                CFG_BG_COLOR:  r_bg_color  <= i_cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel group: the byte itself, or its bits expanded MSB first to colors.
    always_comb begin
        n_pixel_bytes = '0;
        n_pixel_count = PIX_CNT_BYTE;
        if (r_mono_mode) begin
            for (int k = 0; k < PIX_PER_BYTE; k++) begin
                n_pixel_bytes[k*BYTE_W +: BYTE_W] = i_byte[k] ? r_bg_color : r_fg_color;
            end
            n_pixel_count = PIX_CNT_MONO;
        end else begin
            n_pixel_bytes[BYTE_W-1:0] = i_byte;
        end
    end

    // The result register takes a new group whenever its slot is free.
    assign o_s2_free = !r_valid || out_ch.ready;
    assign load      = i_adv && i_dec.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s2_free) begin
            r_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && o_s2_free) begin
            r_pixel_bytes  <= n_pixel_bytes;
            r_pixel_count  <= n_pixel_count;
            r_repeat_count <= i_dec.repeat_count;
        end
    end

    assign out_ch.valid        = r_valid;
    assign out_ch.pixel_bytes  = r_pixel_bytes;
    assign out_ch.pixel_count  = r_pixel_count;
    assign out_ch.repeat_count = r_repeat_count;

endmodule
`default_nettype wire

// File: design/rle_mono_bitmap_decoder_unit.sv
`default_nettype none
// A result passes through the input register and then the result register.
// Throughput: one stream byte per cycle while the sink does not stall the result register.
// A count byte is accepted like any other byte but produces no output transaction.
// Reset (synchronous, active low) clears the run counter and both valid flags and
// returns the configuration registers to byte mode, foreground 0, background 255.
// ----------------------------------------------------------------------------
// rle_mono_bitmap_decoder_unit: signed-count run-length bitmap decoder
// Input register, run counter decision and pixel formatting into a result
// register that carries the group and its repeat count.
// ----------------------------------------------------------------------------
module rle_mono_bitmap_decoder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rmbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmbd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    rmbd_in_if.sink                              i_in_ch,
    rmbd_out_if.source                           o_out_ch
);
    import rmbd_pkg::*;

    logic              s2_free;
    logic              adv;
    logic [BYTE_W-1:0] s1_byte;
    logic              s1_last;
    t_run_dec          dec;

    // Input register.
    rmbd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (i_in_ch),
        .i_s2_free (s2_free),
        .o_adv     (adv),
        .o_byte    (s1_byte),
        .o_last    (s1_last)
    );

    // Run counter and byte role decision.
    rmbd_run_ctrl u_run_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (s1_byte),
        .i_last  (s1_last),
        .o_dec   (dec)
    );

    // Pixel formatting and result register.
    rmbd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_byte      (s1_byte),
        .i_dec       (dec),
        .o_s2_free   (s2_free),
        .out_ch      (o_out_ch)
    );

endmodule
`default_nettype wire

// File: sim/tb_rle_mono_bitmap_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rle_mono_bitmap_decoder_unit: self-checking bench of the RLE bitmap decoder
// Streams directed and random run-length sequences through the decoder in byte
// and monochrome modes. A pixel group tracker predicts each output transaction
// from the accepted stream bytes and checks the results in order, while both
// channel sides idle in random bursts and the receiver holds off once.
// ----------------------------------------------------------------------------

// One pixel group as the decoder should emit it.
typedef struct {
    logic [rmbd_pkg::PIX_BYTES_W-1:0] pixel_bytes;
    logic [rmbd_pkg::PIX_CNT_W-1:0]   pixel_count;
    logic [rmbd_pkg::REPEAT_W-1:0]    repeat_count;
} t_pixel_group;

// Tracks the run counter and register copies, and holds the pixel groups
// still due from the decoder.
class pixel_group_tracker;
    logic                           mono_mode;
    logic [rmbd_pkg::BYTE_W-1:0]    fg_color;
    logic [rmbd_pkg::BYTE_W-1:0]    bg_color;
    logic [rmbd_pkg::BYTE_W-1:0]    run_cnt;
    t_pixel_group                   due_groups[$];
    int                             fail_count;

    function new();
        mono_mode  = rmbd_pkg::MONO_MODE_RST;
        fg_color   = rmbd_pkg::FG_COLOR_RST;
        bg_color   = rmbd_pkg::BG_COLOR_RST;
        run_cnt    = '0;
        fail_count = 0;
    endfunction

    // Register writes outside the list have no effect.
    function void apply_config(logic [rmbd_pkg::CFG_IDX_W-1:0] idx,
                               logic [rmbd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            rmbd_pkg::CFG_MONO_MODE: mono_mode = val[0];
            rmbd_pkg::CFG_FG_COLOR:  fg_color  = val;
            rmbd_pkg::CFG_BG_COLOR:  bg_color  = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return due_groups.size();
    endfunction

    // Works out what one accepted stream byte does to the counter and output.
    function void note_stream_byte(logic [rmbd_pkg::BYTE_W-1:0] data, logic last);
        t_pixel_group grp;
        logic         emit;
        emit = 1'b0;
        if (run_cnt == '0) begin
            run_cnt = data;
        end else if (!run_cnt[7]) begin
            grp.repeat_count = run_cnt[6:0];
            run_cnt = '0;
            emit = 1'b1;
        end else begin
            grp.repeat_count = rmbd_pkg::REPEAT_ONE;
            run_cnt = run_cnt + 8'd1;
            emit = 1'b1;
        end
        if (emit) begin
            if (mono_mode) begin
                // First pixel comes from bit 7 and lands in the top byte.
                for (int i = 0; i < rmbd_pkg::PIX_PER_BYTE; i++)
                    grp.pixel_bytes[63-8*i -: 8] = data[7-i] ? bg_color : fg_color;
                grp.pixel_count = rmbd_pkg::PIX_CNT_MONO;
            end else begin
                grp.pixel_bytes = {56'd0, data};
                grp.pixel_count = rmbd_pkg::PIX_CNT_BYTE;
            end
            due_groups.push_back(grp);
        end
        if (last)
            run_cnt = '0;
    endfunction

    // Compares one output transaction with the oldest due group.
    function void check_pixel_group(logic [rmbd_pkg::PIX_BYTES_W-1:0] bytes_act,
                                    logic [rmbd_pkg::PIX_CNT_W-1:0] count_act,
                                    logic [rmbd_pkg::REPEAT_W-1:0] repeat_act);
        t_pixel_group exp_grp;
        if (due_groups.size() == 0) begin
            $error("unexpected pixel group: pixel_bytes %h pixel_count %0d repeat_count %0d",
                   bytes_act, count_act, repeat_act);
            fail_count++;
            return;
        end
        exp_grp = due_groups.pop_front();
        if (bytes_act !== exp_grp.pixel_bytes) begin
            $error("pixel_bytes: expected %h, actual %h", exp_grp.pixel_bytes, bytes_act);
            fail_count++;
        end
        if (count_act !== exp_grp.pixel_count) begin
            $error("pixel_count: expected %0d, actual %0d", exp_grp.pixel_count, count_act);
            fail_count++;
        end
        if (repeat_act !== exp_grp.repeat_count) begin
            $error("repeat_count: expected %0d, actual %0d", exp_grp.repeat_count,
                   repeat_act);
            fail_count++;
        end
    endfunction
endclass

module tb_rle_mono_bitmap_decoder_unit;
    import rmbd_pkg::*;

    // Index past the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PHASE_BYTES     = 106;
    localparam int RANDOM_PHASES   = 5;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rmbd_in_if  in_ch ();
    rmbd_out_if out_ch ();

    pixel_group_tracker tracker;
    bit                 idle_en;
    bit                 hold_off_req;
    int                 cycle_cnt;

    rle_mono_bitmap_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up on a hung run.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && idle_en && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check every output transaction against the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_pixel_group(out_ch.pixel_bytes, out_ch.pixel_count,
                                      out_ch.repeat_count);
    end

    // Offers one stream byte, starting and ending at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= data;
        in_ch.last_of_image <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_stream_byte(data, last);
        @(negedge i_clk);
    endtask

    // Stops the stream and waits until the decoder has nothing left in flight.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        tracker.apply_config(idx, val);
        @(negedge i_clk);
    endtask

    // Writes all registers back to back; upper data bits of the mode are noise.
    task automatic set_registers(input logic mono, input logic [BYTE_W-1:0] fg,
                                 input logic [BYTE_W-1:0] bg, input bit touch_spare);
        cfg_write(CFG_MONO_MODE, {7'($urandom), mono});
        cfg_write(CFG_FG_COLOR, fg);
        cfg_write(CFG_BG_COLOR, bg);
        if (touch_spare)
            cfg_write(CFG_IDX_SPARE, 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Positive count followed by its data byte; sometimes the image ends early.
    task automatic send_repeat_run(inout int sent);
        logic [BYTE_W-1:0] cnt;
        int unsigned       pick;
        pick = $urandom_range(0, 7);
        cnt  = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd127 : 8'($urandom_range(1, 127));
        if ($urandom_range(0, 11) == 0) begin
            send_byte(cnt, 1'b1);
            sent++;
            return;
        end
        send_byte(cnt, 1'b0);
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        sent += 2;
    endtask

    // Negative count and its literals; a last flag may cut the sequence short.
    task automatic send_literal_run(inout int sent);
        int unsigned len;
        int unsigned cut;
        logic        last;
        len = ($urandom_range(0, 14) == 0) ? 128 : $urandom_range(1, 8);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len + 1;
        send_byte(8'(256 - len), cut == 0);
        sent++;
        for (int k = 1; k <= len && cut != 0; k++) begin
            last = (k == cut) || (k == len && $urandom_range(0, 7) == 0);
            send_byte(8'($urandom), last);
            sent++;
            if (k == cut)
                break;
        end
    endtask

    // One random piece of stream: mostly well formed runs, some noise.
    task automatic send_random_piece(inout int sent);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            send_repeat_run(sent);
        end else if (kind <= 6) begin
            send_literal_run(sent);
        end else if (kind == 7) begin
            send_byte(8'd0, 1'($urandom_range(0, 1)));
            sent++;
        end else begin
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            sent++;
        end
    endtask

    initial begin
        int sent;
        tracker             = new();
        idle_en             = 1'b1;
        hold_off_req        = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_wdata         = '0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.last_of_image = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Byte mode at reset values: zero count, count extremes, data extremes,
        // most negative count cut short by the last byte, count byte as last.
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h02, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        // Monochrome with default-like colors; a run ended by the last byte.
        set_registers(1'b1, 8'h00, 8'hFF, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h11, 1'b1);
        wait_drained();

        // Swapped color extremes and a write to the unused index.
        set_registers(1'b1, 8'hFF, 8'h00, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        wait_drained();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_registers(1'b0, 8'($urandom), 8'($urandom), 1'b1);
                1: set_registers(1'b1, 8'($urandom), 8'($urandom), 1'b0);
                2: set_registers(1'b1, 8'h00, 8'hFF, 1'b0);
                3: set_registers(1'b0, 8'hFF, 8'h00, 1'b1);
                default: set_registers(1'b1, 8'($urandom), 8'($urandom), 1'b1);
            endcase
            // The receiver holds off while the sender keeps offering bytes.
            if (phase == 2)
                hold_off_req = 1'b1;
            // Full rate on both sides at the end of the run.
            if (phase == RANDOM_PHASES - 1)
                idle_en = 1'b0;
            sent = 0;
            while (sent < PHASE_BYTES)
                send_random_piece(sent);
            wait_drained();
        end

        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (tracker.pending() != 0)
                $error("%0d pixel groups never arrived", tracker.pending());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: rle_mono_bitmap_decoder_unit.f
design/rmbd_pkg.sv
design/rmbd_in_if.sv
design/rmbd_out_if.sv
design/rmbd_in_stage.sv
design/rmbd_run_ctrl.sv
design/rmbd_out_stage.sv
design/rle_mono_bitmap_decoder_unit.sv
sim/tb_rle_mono_bitmap_decoder_unit.sv
